>>> rtl/gr_pkg.sv
// ----------------------------------------------------------------------------
// gr_pkg: shared types and constants for the gyro rate conditioning block
// Payload structs, register indexes, reset values, sequencer states, lane and
// merge control bundles, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package gr_pkg;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned SampleW = 16;
  localparam int unsigned RateW   = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SelW    = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegOffsets = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRowX    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRowY    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRowZ    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAlpha   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScale   = 3'd5;

  // reset values: identity matrix in Q2.13, unity alpha
  localparam logic [CfgW-1:0]   RowXRst  = 48'h0000_0000_2000;
  localparam logic [CfgW-1:0]   RowYRst  = 48'h0000_2000_0000;
  localparam logic [CfgW-1:0]   RowZRst  = 48'h2000_0000_0000;
  localparam logic [AlphaW-1:0] AlphaOne = 17'h10000;
  localparam logic [ScaleW-1:0] ScaleRst = 32'd5247384;

  // saturation bounds on a 40-bit intermediate
  localparam logic signed [39:0] RateMax = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] RateMin = -40'sh00_8000_0000;

  typedef struct packed {
    logic [7:0]  x_high_byte;
    logic [7:0]  x_low_byte;
    logic [7:0]  y_high_byte;
    logic [7:0]  y_low_byte;
    logic [7:0]  z_high_byte;
    logic [7:0]  z_low_byte;
    logic [31:0] now_ms;
  } gr_in_t;

  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
    logic               data_valid;
    logic [31:0]        change_time_ms;
  } gr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SAT,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_ACC,
    ST_ROUND,
    ST_FMUL,
    ST_FUPD,
    ST_DONE
  } gr_state_e;

  // per-step enables for every lane
  typedef struct packed {
    logic            scale_en;
    logic            sat_en;
    logic            mac_en;
    logic [SelW-1:0] mac_sel;
    logic            acc_en;
    logic            acc_clr;
    logic            round_en;
    logic            fmul_en;
    logic            fupd_en;
  } gr_lane_ctl_t;

  typedef struct packed {
    logic track;
    logic load;
  } gr_merge_ctl_t;

  function automatic logic signed [RateW-1:0] sat_rate(input logic signed [39:0] v);
    logic signed [RateW-1:0] r;
    if (v > RateMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < RateMin) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[RateW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/gr_lane.sv
// ----------------------------------------------------------------------------
// gr_lane: one axis of the conditioning datapath
// Offset/negate/scale, one row of the alignment matrix as a three-step
// multiply-accumulate, then the exponential low-pass filter with its state.
// ----------------------------------------------------------------------------
module gr_lane (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  gr_pkg::gr_lane_ctl_t                         ctl_i,
  input  logic [gr_pkg::SampleW-1:0]                   sample_i,
  input  logic [gr_pkg::SampleW-1:0]                   offset_i,
  input  logic [gr_pkg::ScaleW-1:0]                    scale_i,
  input  logic [gr_pkg::AlphaW-1:0]                    alpha_i,
  input  logic [gr_pkg::CfgW-1:0]                      row_i,
  input  logic [gr_pkg::NumAxes-1:0][gr_pkg::RateW-1:0] g_all_i,
  output logic [gr_pkg::RateW-1:0]                     g_o,
  output logic [gr_pkg::RateW-1:0]                     rate_o
);

  logic signed [16:0] diff_s;
  logic signed [49:0] prod_d, prod_q;
  logic signed [31:0] g_q;
  logic signed [15:0] coef;
  logic signed [31:0] g_sel;
  logic signed [47:0] mprod_d, mprod_q;
  logic signed [49:0] acc_base, acc_d, acc_q;
  logic signed [31:0] r_d, r_q;
  logic signed [32:0] fdiff;
  logic signed [50:0] fprod_d, fprod_q;
  logic signed [31:0] x_d, x_q;

  // d = offset - sample, then times unsigned scale
  assign diff_s = $signed({offset_i[15], offset_i}) - $signed({sample_i[15], sample_i});
  assign prod_d = diff_s * $signed({1'b0, scale_i});

  // matrix tap for this step
  assign coef    = $signed(row_i[ctl_i.mac_sel * gr_pkg::CoefW +: gr_pkg::CoefW]);
  assign g_sel   = $signed(g_all_i[ctl_i.mac_sel]);
  assign mprod_d = coef * g_sel;

  assign acc_base = ctl_i.acc_clr ? 50'sd0 : acc_q;
  assign acc_d    = acc_base + {{2{mprod_q[47]}}, mprod_q};
  assign r_d      = gr_pkg::sat_rate(40'(acc_q >>> 13));

  // filter: X += ((r - X) * alpha) >> 16
  assign fdiff   = 33'(r_q) - 33'(x_q);
  assign fprod_d = fdiff * $signed({1'b0, alpha_i});
  assign x_d     = gr_pkg::sat_rate(40'(x_q) + 40'(fprod_q >>> 16));

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.scale_en) prod_q  <= prod_d;
    if (ctl_i.sat_en)   g_q     <= gr_pkg::sat_rate(40'(prod_q >>> 16));
    if (ctl_i.mac_en)   mprod_q <= mprod_d;
    if (ctl_i.acc_en)   acc_q   <= acc_d;
    if (ctl_i.round_en) r_q     <= r_d;
    if (ctl_i.fmul_en)  fprod_q <= fprod_d;
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
    end else if (ctl_i.fupd_en) begin
      x_q <= x_d;
    end
  end

  assign g_o    = g_q;
  assign rate_o = x_q;

endmodule

>>> rtl/gr_merge.sv
// ----------------------------------------------------------------------------
// gr_merge: change tracking and result register
// Keeps the previous frame, the sticky valid flag and the change time, and
// packs the lane results into the output register that feeds the out channel.
// ----------------------------------------------------------------------------
module gr_merge (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  gr_pkg::gr_merge_ctl_t                          ctl_i,
  input  logic [gr_pkg::NumAxes-1:0][gr_pkg::SampleW-1:0] samples_i,
  input  logic [31:0]                                    now_ms_i,
  input  logic [gr_pkg::NumAxes-1:0][gr_pkg::RateW-1:0]   rates_i,
  input  logic                                           out_ready_i,
  output logic                                           out_valid_o,
  output gr_pkg::gr_out_t                                out_data_o
);

  logic [gr_pkg::NumAxes-1:0][gr_pkg::SampleW-1:0] prev_q;
  logic        flag_q;
  logic [31:0] time_q;
  logic        changed;
  logic        valid_q;
  gr_pkg::gr_out_t out_q;

  assign changed = (samples_i != prev_q);

  // previous frame, sticky flag, change time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      flag_q <= 1'b0;
      time_q <= '0;
    end else if (ctl_i.track) begin
      prev_q <= samples_i;
      if (changed) begin
        flag_q <= 1'b1;
        time_q <= now_ms_i;
      end
    end
  end

  // output valid: set on load, cleared on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      out_q.rate_x         <= rates_i[0];
      out_q.rate_y         <= rates_i[1];
      out_q.rate_z         <= rates_i[2];
      out_q.sample_x       <= samples_i[0];
      out_q.sample_y       <= samples_i[1];
      out_q.sample_z       <= samples_i[2];
      out_q.data_valid     <= flag_q;
      out_q.change_time_ms <= time_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/gyro_rate_condition_core.sv
// ----------------------------------------------------------------------------
// gyro_rate_condition_core: gyro frame conditioning top level
// Registers configuration, sequences three axis lanes through scale, matrix
// rotation and low-pass filtering, and hands results to the merge stage.
// ----------------------------------------------------------------------------
// Each frame steps all lanes through the sequencer states: scale, saturate, three matrix taps,
//   accumulate, round, filter multiply, update and load; the load waits until the output
//   register is free. A new frame is accepted only once the sequencer is back in idle.
// A finished result waits in the output register while the next frame runs.
// Reset (async, active low): identity matrix, zero offsets, unity alpha,
//   default scale; filter state, previous frame, flag and change time cleared.
module gyro_rate_condition_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gr_pkg::gr_in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gr_pkg::gr_out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gr_pkg::CfgW-1:0]       cfg_data_i
);

  logic [gr_pkg::CfgW-1:0]   offsets_q;
  logic [gr_pkg::CfgW-1:0]   row_q [gr_pkg::NumAxes];
  logic [gr_pkg::AlphaW-1:0] alpha_q;
  logic [gr_pkg::ScaleW-1:0] scale_q;
  logic [gr_pkg::AlphaW-1:0] alpha_eff;

  gr_pkg::gr_state_e     state_q, state_d;
  gr_pkg::gr_lane_ctl_t  lane_ctl;
  gr_pkg::gr_merge_ctl_t merge_ctl;
  gr_pkg::gr_in_t        in_q;
  logic                  in_xfer;

  logic [gr_pkg::NumAxes-1:0][gr_pkg::SampleW-1:0] samples;
  logic [gr_pkg::NumAxes-1:0][gr_pkg::RateW-1:0]   g_all;
  logic [gr_pkg::NumAxes-1:0][gr_pkg::RateW-1:0]   rates;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
      row_q[0]  <= gr_pkg::RowXRst;
      row_q[1]  <= gr_pkg::RowYRst;
      row_q[2]  <= gr_pkg::RowZRst;
      alpha_q   <= gr_pkg::AlphaOne;
      scale_q   <= gr_pkg::ScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gr_pkg::RegOffsets: offsets_q <= cfg_data_i;
        gr_pkg::RegRowX:    row_q[0]  <= cfg_data_i;
        gr_pkg::RegRowY:    row_q[1]  <= cfg_data_i;
        gr_pkg::RegRowZ:    row_q[2]  <= cfg_data_i;
        gr_pkg::RegAlpha:   alpha_q   <= cfg_data_i[gr_pkg::AlphaW-1:0];
        gr_pkg::RegScale:   scale_q   <= cfg_data_i[gr_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_eff = (alpha_q > gr_pkg::AlphaOne) ? gr_pkg::AlphaOne : alpha_q;

  // input frame register
  assign in_ready_o = (state_q == gr_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_xfer) in_q <= in_data_i;
  end

  assign samples[0] = {in_q.x_high_byte, in_q.x_low_byte};
  assign samples[1] = {in_q.y_high_byte, in_q.y_low_byte};
  assign samples[2] = {in_q.z_high_byte, in_q.z_low_byte};

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and step enables
  always_comb begin
    state_d   = state_q;
    lane_ctl  = '0;
    merge_ctl = '0;
    case (state_q)
      gr_pkg::ST_IDLE: begin
        if (in_xfer) state_d = gr_pkg::ST_SCALE;
      end
      gr_pkg::ST_SCALE: begin
        lane_ctl.scale_en = 1'b1;
        merge_ctl.track   = 1'b1;
        state_d           = gr_pkg::ST_SAT;
      end
      gr_pkg::ST_SAT: begin
        lane_ctl.sat_en = 1'b1;
        state_d         = gr_pkg::ST_MAC0;
      end
      gr_pkg::ST_MAC0: begin
        lane_ctl.mac_en  = 1'b1;
        lane_ctl.mac_sel = 2'd0;
        state_d          = gr_pkg::ST_MAC1;
      end
      gr_pkg::ST_MAC1: begin
        lane_ctl.mac_en  = 1'b1;
        lane_ctl.mac_sel = 2'd1;
        lane_ctl.acc_en  = 1'b1;
        lane_ctl.acc_clr = 1'b1;
        state_d          = gr_pkg::ST_MAC2;
      end
      gr_pkg::ST_MAC2: begin
        lane_ctl.mac_en  = 1'b1;
        lane_ctl.mac_sel = 2'd2;
        lane_ctl.acc_en  = 1'b1;
        state_d          = gr_pkg::ST_ACC;
      end
      gr_pkg::ST_ACC: begin
        lane_ctl.acc_en = 1'b1;
        state_d         = gr_pkg::ST_ROUND;
      end
      gr_pkg::ST_ROUND: begin
        lane_ctl.round_en = 1'b1;
        state_d           = gr_pkg::ST_FMUL;
      end
      gr_pkg::ST_FMUL: begin
        lane_ctl.fmul_en = 1'b1;
        state_d          = gr_pkg::ST_FUPD;
      end
      gr_pkg::ST_FUPD: begin
        lane_ctl.fupd_en = 1'b1;
        state_d          = gr_pkg::ST_DONE;
      end
      gr_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_o || out_ready_i) begin
          merge_ctl.load = 1'b1;
          state_d        = gr_pkg::ST_IDLE;
        end
      end
      default: state_d = gr_pkg::ST_IDLE;
    endcase
  end

  // one lane per axis
  for (genvar a = 0; a < gr_pkg::NumAxes; a++) begin : g_lane
    gr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sample_i (samples[a]),
      .offset_i (offsets_q[a*gr_pkg::SampleW +: gr_pkg::SampleW]),
      .scale_i  (scale_q),
      .alpha_i  (alpha_eff),
      .row_i    (row_q[a]),
      .g_all_i  (g_all),
      .g_o      (g_all[a]),
      .rate_o   (rates[a])
    );
  end

  gr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (merge_ctl),
    .samples_i   (samples),
    .now_ms_i    (in_q.now_ms),
    .rates_i     (rates),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == gr_pkg::ST_SCALE))
    else $error("input transfer did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_ctl.load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before transfer");

  a_filter_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gr_pkg::ST_FUPD) |=> (state_q == gr_pkg::ST_DONE))
    else $error("filter update not followed by result stage");
`endif

endmodule

>>> tb/gyro_rate_condition_checker.sv
// ----------------------------------------------------------------------------
// gyro_rate_condition_checker: scoreboard for the gyro rate conditioning core
// Mirrors the register file from the configuration port, predicts one result
// per accepted frame and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module gyro_rate_condition_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  gr_pkg::gr_in_t              in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  gr_pkg::gr_out_t             out_data_i,
  input  logic                        cfg_we_i,
  input  logic [gr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gr_pkg::CfgW-1:0]     cfg_data_i,
  output int                          fail_count_o,
  output int                          result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register mirror
  logic [gr_pkg::CfgW-1:0]   offsets_q;
  logic [gr_pkg::CfgW-1:0]   rows_q [gr_pkg::NumAxes];
  logic [gr_pkg::AlphaW-1:0] alpha_q;
  logic [gr_pkg::ScaleW-1:0] scale_q;

  // conditioning state
  logic signed [gr_pkg::SampleW-1:0] held_sample [gr_pkg::NumAxes];
  logic signed [gr_pkg::RateW-1:0]   filt_rate   [gr_pkg::NumAxes];
  logic                              valid_flag;
  logic [31:0]                       change_ms;

  gr_pkg::gr_out_t expected_results [$];
  gr_pkg::gr_out_t want;
  int              fail_count;

  assign fail_count_o = fail_count;

  function automatic longint coef_lane(input logic [gr_pkg::CfgW-1:0] word, input int idx);
    logic signed [15:0] v;
    v = word[16*idx +: 16];
    return longint'(v);
  endfunction

  function automatic logic signed [gr_pkg::RateW-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  // one frame through offset, scale, rotation and low-pass; updates state
  function automatic gr_pkg::gr_out_t condition_frame(input gr_pkg::gr_in_t f);
    logic signed [gr_pkg::SampleW-1:0] smp [gr_pkg::NumAxes];
    longint                            scaled [gr_pkg::NumAxes];
    longint                            diff, acc, rot, alpha_eff, prev;
    gr_pkg::gr_out_t                   res;
    smp[0] = {f.x_high_byte, f.x_low_byte};
    smp[1] = {f.y_high_byte, f.y_low_byte};
    smp[2] = {f.z_high_byte, f.z_low_byte};
    if (smp[0] != held_sample[0] || smp[1] != held_sample[1] ||
        smp[2] != held_sample[2]) begin
      valid_flag = 1'b1;
      change_ms  = f.now_ms;
    end
    for (int i = 0; i < gr_pkg::NumAxes; i++) begin
      diff = -(longint'(smp[i]) - coef_lane(offsets_q, i));
      scaled[i] = longint'(clamp32((diff * longint'(scale_q)) >>> 16));
      held_sample[i] = smp[i];
    end
    alpha_eff = (alpha_q > gr_pkg::AlphaOne) ? 64'sd65536 : longint'(alpha_q);
    for (int i = 0; i < gr_pkg::NumAxes; i++) begin
      acc = 0;
      for (int j = 0; j < gr_pkg::NumAxes; j++) begin
        acc += coef_lane(rows_q[i], j) * scaled[j];
      end
      rot  = longint'(clamp32(acc >>> 13));
      prev = longint'(filt_rate[i]);
      filt_rate[i] = clamp32(prev + (((rot - prev) * alpha_eff) >>> 16));
    end
    res.rate_x         = filt_rate[0];
    res.rate_y         = filt_rate[1];
    res.rate_z         = filt_rate[2];
    res.sample_x       = smp[0];
    res.sample_y       = smp[1];
    res.sample_z       = smp[2];
    res.data_valid     = valid_flag;
    res.change_time_ms = change_ms;
    return res;
  endfunction

  function automatic void compare_field(input string name,
                                        input logic signed [63:0] exp_v,
                                        input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // track transfers, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q  = '0;
      rows_q[0]  = gr_pkg::RowXRst;
      rows_q[1]  = gr_pkg::RowYRst;
      rows_q[2]  = gr_pkg::RowZRst;
      alpha_q    = gr_pkg::AlphaOne;
      scale_q    = gr_pkg::ScaleRst;
      for (int i = 0; i < gr_pkg::NumAxes; i++) begin
        held_sample[i] = '0;
        filt_rate[i]   = '0;
      end
      valid_flag = 1'b0;
      change_ms  = '0;
      expected_results.delete();
      fail_count = 0;
      result_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no frame outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("rate_x", want.rate_x, out_data_i.rate_x);
          compare_field("rate_y", want.rate_y, out_data_i.rate_y);
          compare_field("rate_z", want.rate_z, out_data_i.rate_z);
          compare_field("sample_x", want.sample_x, out_data_i.sample_x);
          compare_field("sample_y", want.sample_y, out_data_i.sample_y);
          compare_field("sample_z", want.sample_z, out_data_i.sample_z);
          compare_field("data_valid", want.data_valid, out_data_i.data_valid);
          compare_field("change_time_ms", want.change_time_ms,
                        out_data_i.change_time_ms);
        end
        result_count_o <= result_count_o + 1;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(condition_frame(in_data_i));
      end
      // register writes; spare indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gr_pkg::RegOffsets: offsets_q = cfg_data_i;
          gr_pkg::RegRowX:    rows_q[0] = cfg_data_i;
          gr_pkg::RegRowY:    rows_q[1] = cfg_data_i;
          gr_pkg::RegRowZ:    rows_q[2] = cfg_data_i;
          gr_pkg::RegAlpha:   alpha_q   = cfg_data_i[gr_pkg::AlphaW-1:0];
          gr_pkg::RegScale:   scale_q   = cfg_data_i[gr_pkg::ScaleW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/gyro_rate_condition_core_tb.sv
// ----------------------------------------------------------------------------
// gyro_rate_condition_core_tb: top-level testbench for the gyro rate core
// Directed frames at the sample and register extremes, then random frames
// under several register settings with sender and receiver stalls; results
// are checked by the scoreboard module.
// ----------------------------------------------------------------------------
module gyro_rate_condition_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit     = 1_000_000;
  localparam int DrainCycles    = 16;
  localparam int FramesPerSet   = 163;
  localparam int SetsPerPhase   = 4;
  localparam logic [gr_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [gr_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  gr_pkg::gr_in_t             in_data_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  gr_pkg::gr_out_t            out_data_o;
  logic                       cfg_we_i   = 1'b0;
  logic [gr_pkg::CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [gr_pkg::CfgW-1:0]    cfg_data_i = '0;

  int             fail_count;
  int             result_count;
  int             frames_sent     = 0;
  int             settings_loaded = 0;
  int             send_idle_pct   = 0;
  int             recv_idle_pct   = 0;
  int             cycle_count     = 0;
  gr_pkg::gr_in_t last_frame      = '0;

  gyro_rate_condition_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  gyro_rate_condition_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .result_count_o (result_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic gr_pkg::gr_in_t make_frame(input logic [15:0] sx, sy, sz,
                                                input logic [31:0] stamp);
    gr_pkg::gr_in_t f;
    f.x_high_byte = sx[15:8];
    f.x_low_byte  = sx[7:0];
    f.y_high_byte = sy[15:8];
    f.y_low_byte  = sy[7:0];
    f.z_high_byte = sz[15:8];
    f.z_low_byte  = sz[7:0];
    f.now_ms      = stamp;
    return f;
  endfunction

  // repeats, small steps, fresh values or corners, on a mostly rising clock
  function automatic gr_pkg::gr_in_t next_frame(input gr_pkg::gr_in_t prev);
    logic [15:0] s [gr_pkg::NumAxes];
    logic [15:0] corner [4];
    logic [31:0] stamp;
    int          mode;
    corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    s[0] = {prev.x_high_byte, prev.x_low_byte};
    s[1] = {prev.y_high_byte, prev.y_low_byte};
    s[2] = {prev.z_high_byte, prev.z_low_byte};
    mode = $urandom_range(9);
    for (int i = 0; i < gr_pkg::NumAxes; i++) begin
      if (mode >= 3 && mode <= 5) begin
        s[i] = s[i] + 16'($urandom_range(64)) - 16'd32;
      end else if (mode >= 6 && mode <= 8) begin
        s[i] = 16'($urandom);
      end else if (mode == 9) begin
        s[i] = corner[$urandom_range(3)];
      end
    end
    stamp = ($urandom_range(19) == 0) ? $urandom : prev.now_ms + $urandom_range(3);
    return make_frame(s[0], s[1], s[2], stamp);
  endfunction

  // hold valid until the transfer, then maybe leave a gap
  task automatic send_frame(input gr_pkg::gr_in_t f);
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
    last_frame = f;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic write_reg(input logic [gr_pkg::CfgIdxW-1:0] idx,
                           input logic [gr_pkg::CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain the block, then load a full register set
  task automatic write_all(input logic [gr_pkg::CfgW-1:0] offs, rx, ry, rz,
                           input logic [gr_pkg::AlphaW-1:0] alpha,
                           input logic [gr_pkg::ScaleW-1:0] scale);
    in_valid_i <= 1'b0;
    while (result_count != frames_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(gr_pkg::RegOffsets, offs);
    write_reg(gr_pkg::RegRowX, rx);
    write_reg(gr_pkg::RegRowY, ry);
    write_reg(gr_pkg::RegRowZ, rz);
    write_reg(gr_pkg::RegAlpha, gr_pkg::CfgW'(alpha));
    write_reg(gr_pkg::RegScale, gr_pkg::CfgW'(scale));
    settings_loaded++;
  endtask

  initial begin
    logic [gr_pkg::CfgW-1:0]   offs;
    logic [gr_pkg::CfgW-1:0]   rows [gr_pkg::NumAxes];
    logic [gr_pkg::AlphaW-1:0] alpha;
    logic [gr_pkg::ScaleW-1:0] scale;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero first frame is no change, repeats keep the time
    send_frame(make_frame(16'h0000, 16'h0000, 16'h0000, 32'd100));
    send_frame(make_frame(16'h0000, 16'h0000, 16'h0000, 32'd101));
    send_frame(make_frame(16'h7FFF, 16'h8000, 16'hFFFF, 32'd102));
    send_frame(make_frame(16'h7FFF, 16'h8000, 16'hFFFF, 32'd103));
    send_frame(make_frame(16'h8000, 16'h7FFF, 16'h0001, 32'd0));
    send_frame(make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_frame(make_frame(16'h00FF, 16'hFF00, 16'h5AA5, 32'h8000_0000));

    // extreme offsets, coefficients and scale; alpha above one is clamped
    write_all({16'hFFFF, 16'h7FFF, 16'h8000},
              {16'h8000, 16'h7FFF, 16'h7FFF},
              {16'h8000, 16'h8000, 16'h8000},
              {16'h7FFF, 16'h0000, 16'h8000},
              17'h1FFFF, 32'hFFFF_FFFF);
    // spare indexes must not disturb anything
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, '1);
    send_frame(make_frame(16'h7FFF, 16'h8000, 16'h0000, 32'd200));
    send_frame(make_frame(16'h8000, 16'h7FFF, 16'hFFFF, 32'd201));
    send_frame(make_frame(16'h0000, 16'h0000, 16'h0000, 32'd202));

    // alpha zero: filter holds whatever it had
    write_all('0, '0, '0, '0, '0, '0);
    send_frame(make_frame(16'h1234, 16'hEDCB, 16'h0F0F, 32'd300));
    send_frame(make_frame(16'h8000, 16'h7FFF, 16'h0000, 32'd301));

    // smallest alpha with full scale
    write_all('0, gr_pkg::RowXRst, gr_pkg::RowYRst, gr_pkg::RowZRst, 17'd1, 32'hFFFF_FFFF);
    send_frame(make_frame(16'h7FFF, 16'h8000, 16'h4000, 32'd400));
    send_frame(make_frame(16'h8000, 16'h7FFF, 16'hC000, 32'd401));
    send_frame(make_frame(16'h0001, 16'hFFFF, 16'h0000, 32'd402));

    // negated identity, alpha just below one
    write_all({16'h0064, 16'hFF9C, 16'h0000},
              {16'h0000, 16'h0000, 16'hE000},
              {16'h0000, 16'hE000, 16'h0000},
              {16'hE000, 16'h0000, 16'h0000},
              17'd65535, gr_pkg::ScaleRst);
    send_frame(make_frame(16'h0100, 16'hFF00, 16'h7FFF, 32'd500));
    send_frame(make_frame(16'h0100, 16'hFF00, 16'h7FFF, 32'd501));
    send_frame(make_frame(16'hA5A5, 16'h5A5A, 16'h8000, 32'd502));

    // random frames: idling on both sides swapped, then none at all
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 14 : 0;
      for (int set = 0; set < SetsPerPhase; set++) begin
        for (int k = 0; k < gr_pkg::NumAxes; k++) begin
          case ($urandom_range(3))
            0:       offs[16*k +: 16] = 16'($urandom);
            1:       offs[16*k +: 16] = 16'h7FFF;
            2:       offs[16*k +: 16] = 16'h8000;
            default: offs[16*k +: 16] = 16'($urandom_range(200)) - 16'd100;
          endcase
          for (int j = 0; j < gr_pkg::NumAxes; j++) begin
            case ($urandom_range(5))
              0:       rows[k][16*j +: 16] = 16'($urandom);
              1:       rows[k][16*j +: 16] = 16'h7FFF;
              2:       rows[k][16*j +: 16] = 16'h8000;
              3:       rows[k][16*j +: 16] = 16'h0000;
              default: rows[k][16*j +: 16] = 16'($urandom_range(16384)) - 16'd8192;
            endcase
          end
        end
        case ($urandom_range(6))
          0:       alpha = '0;
          1:       alpha = gr_pkg::AlphaOne;
          2:       alpha = 17'($urandom_range(131071, 65537));
          3:       alpha = 17'd1;
          default: alpha = 17'($urandom_range(65535));
        endcase
        case ($urandom_range(5))
          0:       scale = '0;
          1:       scale = 32'hFFFF_FFFF;
          2:       scale = $urandom;
          default: scale = $urandom_range(20_000_000);
        endcase
        write_all(offs, rows[0], rows[1], rows[2], alpha, scale);
        repeat (FramesPerSet) send_frame(next_frame(last_frame));
      end
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (result_count != frames_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d frames and %0d checked results over %0d register sets,",
             frames_sent, result_count, settings_loaded);
    $display("with stalls on either side in turn and a full-rate stretch.");
    if (fail_count == 0 && result_count == frames_sent) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gr_pkg.sv
rtl/gr_lane.sv
rtl/gr_merge.sv
rtl/gyro_rate_condition_core.sv
tb/gyro_rate_condition_checker.sv
tb/gyro_rate_condition_core_tb.sv
